FILE: hdl/mmm_pkg.sv
// Package for the Montgomery modular multiplier: widths, pipeline depths,
// action and register codes, the configuration struct and the remainder step.
// Depends on nothing.
package mmm_pkg;

  localparam int OW         = 32;
  localparam int XW         = 2 * OW;
  localparam int SW         = XW + 1;
  localparam int RBW        = 6;
  localparam int REM_STEP   = 2;
  localparam int REM_STAGES = XW / REM_STEP;
  localparam int FRONT_LAT  = 2;
  localparam int MONT_LAT   = 4;
  localparam int PAD        = REM_STAGES - MONT_LAT;
  localparam int LAT        = FRONT_LAT + REM_STAGES;
  localparam int CFG_AW     = 2;
  localparam int IN_DW      = 72;
  localparam int OUT_DW     = 32;

  localparam logic [1:0] ACT_CIN    = 2'd0;
  localparam logic [1:0] ACT_COUT   = 2'd1;
  localparam logic [1:0] ACT_MUL    = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_RBITS   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_NEGINV  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_RINV    = 2'd3;

  typedef struct packed {
    logic [OW-1:0]  modulus;
    logic [RBW-1:0] rbits;
    logic [OW-1:0]  neg_inv;
    logic [OW-1:0]  rinv;
  } cfg_t;

  function automatic logic [OW-1:0] rem_step(input logic [OW-1:0] rem,
                                             input logic          nbit,
                                             input logic [OW-1:0] modulus);
    logic [OW:0] t;
    t = {rem, nbit};
    if (t >= {1'b0, modulus}) begin
      t = t - {1'b0, modulus};
    end
    return t[OW-1:0];
  endfunction

endpackage

FILE: hdl/montgomery_modular_multiplier.sv
// Top level of the Montgomery modular multiplier: config registers, valid
// pipeline, alignment delay, result select and output register.
// Depends on mmm_pkg, mmm_front, mmm_mont and mmm_rem.
//
//   Channel  Direction  Beat contents
//   in_      slave      action, operand_a, operand_b
//   out_     master     result
//   cfg_     write      register index, data
//
// One beat is accepted per cycle while the output is not stalled; each result
// beat is offered after its input beat passes through two front stages, the
// 32-stage remainder pipeline and the output register.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
module montgomery_modular_multiplier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mmm_pkg::IN_DW-1:0]     in_tdata,   // action, operand_a, operand_b
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mmm_pkg::OUT_DW-1:0]    out_tdata,  // result
  input  logic                          cfg_we,
  input  logic [mmm_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [mmm_pkg::OW-1:0]        cfg_wdata
);
  import mmm_pkg::*;

  logic [OW-1:0]  modulus_r;
  logic [RBW-1:0] rbits_r;
  logic [OW-1:0]  neg_inv_r;
  logic [OW-1:0]  rinv_r;
  cfg_t           cfg;
  logic           adv;
  logic [LAT-1:0] v_r;
  logic           out_valid_r;
  logic [OW-1:0]  out_data_r;
  logic [1:0]     out_act_r;
  logic [XW-1:0]  x_w;
  logic [1:0]     act_w;
  logic [OW-1:0]  mont_w;
  logic [OW-1:0]  rem_w;
  logic [OW-1:0]  pad_r  [PAD];
  logic [1:0]     adel_r [REM_STAGES];
  logic [1:0]     fin_act;
  logic [OW-1:0]  res_nxt;

  assign cfg.modulus = modulus_r;
  assign cfg.rbits   = (rbits_r > RBW'(OW)) ? RBW'(OW) : rbits_r;
  assign cfg.neg_inv = neg_inv_r;
  assign cfg.rinv    = rinv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= OW'(3);
      rbits_r   <= RBW'(2);
      neg_inv_r <= OW'(1);
      rinv_r    <= OW'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MODULUS: modulus_r <= cfg_wdata;
        CFG_RBITS:   rbits_r   <= cfg_wdata[RBW-1:0];
        CFG_NEGINV:  neg_inv_r <= cfg_wdata;
        CFG_RINV:    rinv_r    <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  mmm_front u_front (
    .clk   (clk),
    .adv   (adv),
    .cfg   (cfg),
    .act_i (in_tdata[1:0]),
    .a_i   (in_tdata[33:2]),
    .b_i   (in_tdata[65:34]),
    .x_o   (x_w),
    .act_o (act_w)
  );

  mmm_mont u_mont (
    .clk   (clk),
    .adv   (adv),
    .cfg   (cfg),
    .x_i   (x_w),
    .res_o (mont_w)
  );

  mmm_rem u_rem (
    .clk   (clk),
    .adv   (adv),
    .cfg   (cfg),
    .x_i   (x_w),
    .rem_o (rem_w)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      pad_r[0]  <= mont_w;
      adel_r[0] <= act_w;
      for (int k = 1; k < PAD; k++) begin
        pad_r[k] <= pad_r[k-1];
      end
      for (int k = 1; k < REM_STAGES; k++) begin
        adel_r[k] <= adel_r[k-1];
      end
    end
  end

  assign fin_act = adel_r[REM_STAGES-1];

  always_comb begin
    res_nxt = '0;
    if (modulus_r != '0) begin
      case (fin_act)
        ACT_MUL:           res_nxt = pad_r[PAD-1];
        ACT_CIN, ACT_COUT: res_nxt = rem_w;
        default:           res_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= {v_r[LAT-2:0], in_tvalid};
      out_valid_r <= v_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_nxt;
      out_act_r  <= fin_act;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && modulus_r == '0) |-> out_tdata == '0)
    else $error("nonzero result with zero modulus");

  a_unused_act: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_act_r == ACT_UNUSED) |-> out_tdata == '0)
    else $error("nonzero result for unused action");

  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v_r[LAT-1]))
    else $error("result beat without a pipeline item");

endmodule

FILE: hdl/mmm_front.sv
// Front stages: operand product or radix shift, giving the 64-bit value x.
// Depends on mmm_pkg.
module mmm_front (
  input  logic                   clk,
  input  logic                   adv,
  input  mmm_pkg::cfg_t          cfg,
  input  logic [1:0]             act_i,
  input  logic [mmm_pkg::OW-1:0] a_i,
  input  logic [mmm_pkg::OW-1:0] b_i,
  output logic [mmm_pkg::XW-1:0] x_o,
  output logic [1:0]             act_o
);
  import mmm_pkg::*;

  logic [XW-1:0] prod_r;
  logic [OW-1:0] a1_r;
  logic [1:0]    act1_r;
  logic [XW-1:0] x_r;
  logic [1:0]    act2_r;
  logic [OW-1:0] op2;
  logic [XW-1:0] x_nxt;

  assign op2 = (act_i == ACT_COUT) ? cfg.rinv : b_i;
  assign x_nxt = (act1_r == ACT_CIN) ? (XW'(a1_r) << cfg.rbits) : prod_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= XW'(a_i) * XW'(op2);
      a1_r   <= a_i;
      act1_r <= act_i;
      x_r    <= x_nxt;
      act2_r <= act1_r;
    end
  end

  assign x_o   = x_r;
  assign act_o = act2_r;
endmodule

FILE: hdl/mmm_mont.sv
// Montgomery reduction of x in four stages with a final conditional subtract.
// Depends on mmm_pkg.
module mmm_mont (
  input  logic                   clk,
  input  logic                   adv,
  input  mmm_pkg::cfg_t          cfg,
  input  logic [mmm_pkg::XW-1:0] x_i,
  output logic [mmm_pkg::OW-1:0] res_o
);
  import mmm_pkg::*;

  logic [OW:0]   rm_w;
  logic [OW-1:0] rmask;
  logic [XW-1:0] mprod;
  logic [OW-1:0] m_r;
  logic [XW-1:0] x1_r;
  logic [XW-1:0] mm_r;
  logic [XW-1:0] x2_r;
  logic [SW-1:0] sum;
  logic [SW-1:0] sh;
  logic [XW-1:0] u_r;
  logic [XW-1:0] res_r;

  assign rm_w  = ((OW+1)'(1) << cfg.rbits) - (OW+1)'(1);
  assign rmask = rm_w[OW-1:0];
  assign mprod = XW'(x_i[OW-1:0]) * XW'(cfg.neg_inv);
  assign sum   = SW'(x2_r) + SW'(mm_r);
  assign sh    = sum >> cfg.rbits;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r   <= mprod[OW-1:0] & rmask;
      x1_r  <= x_i;
      mm_r  <= XW'(m_r) * XW'(cfg.modulus);
      x2_r  <= x1_r;
      u_r   <= sh[XW-1:0];
      res_r <= (u_r >= XW'(cfg.modulus)) ? (u_r - XW'(cfg.modulus)) : u_r;
    end
  end

  assign res_o = res_r[OW-1:0];
endmodule

FILE: hdl/mmm_rem.sv
// Pipelined restoring remainder of x by the modulus, two bits per stage.
// Depends on mmm_pkg.
module mmm_rem (
  input  logic                   clk,
  input  logic                   adv,
  input  mmm_pkg::cfg_t          cfg,
  input  logic [mmm_pkg::XW-1:0] x_i,
  output logic [mmm_pkg::OW-1:0] rem_o
);
  import mmm_pkg::*;

  logic [OW-1:0] rem_r [REM_STAGES];
  logic [XW-1:0] xs_r  [REM_STAGES];

  for (genvar k = 0; k < REM_STAGES; k++) begin : g_stage
    logic [OW-1:0] rem_in;
    logic [XW-1:0] xs_in;
    logic [OW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign xs_in  = x_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign xs_in  = xs_r[k-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      for (int s = 0; s < REM_STEP; s++) begin
        rem_nxt = rem_step(rem_nxt, xs_in[XW-1-s], cfg.modulus);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= rem_nxt;
        xs_r[k]  <= xs_in << REM_STEP;
      end
    end
  end

  assign rem_o = rem_r[REM_STAGES-1];
endmodule
